/* rtl/i2cm_pkg.sv */
// Shared types and constants for the two-wire register read sequencer.
package i2cm_pkg;

   // Widths of the request and response payloads.
   localparam int ByteW      = 8;
   localparam int ReqDataW   = 24;
   localparam int RspDataW   = 24;
   localparam int CsrIndexW  = 1;
   localparam int CsrDataW   = 8;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] CSR_SLAVE_ADDRESS = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_MAX_ATTEMPTS  = 1'd1;

   // Reset value of the attempt limit.
   localparam logic [ByteW-1:0] MAX_ATTEMPTS_RESET = 8'd200;

   // Standard bus status codes, low three bits already cleared.
   localparam logic [ByteW-1:0] ST_START      = 8'h08;
   localparam logic [ByteW-1:0] ST_RSTART     = 8'h10;
   localparam logic [ByteW-1:0] ST_SLAW_ACK   = 8'h18;
   localparam logic [ByteW-1:0] ST_SLAW_NACK  = 8'h20;
   localparam logic [ByteW-1:0] ST_TXD_ACK    = 8'h28;
   localparam logic [ByteW-1:0] ST_TXD_NACK   = 8'h30;
   localparam logic [ByteW-1:0] ST_ARB_LOST   = 8'h38;
   localparam logic [ByteW-1:0] ST_SLAR_ACK   = 8'h40;
   localparam logic [ByteW-1:0] ST_SLAR_NACK  = 8'h48;
   localparam logic [ByteW-1:0] ST_RXD_NACK   = 8'h58;

   // Request kinds.
   typedef enum logic {
      KIND_BEGIN  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // Sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_SLAW   = 3'd2,
      PH_REG    = 3'd3,
      PH_RSTART = 3'd4,
      PH_SLAR   = 3'd5,
      PH_DATA   = 3'd6
   } phase_type;

   // Actions commanded to the bus controller.
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_SEND  = 3'd2,
      ACT_RECV  = 3'd3,
      ACT_STOP  = 3'd4
   } action_type;

   // Transaction outcomes.
   typedef enum logic [1:0] {
      OC_BYTE   = 2'd0,
      OC_NODATA = 2'd1,
      OC_ERROR  = 2'd2,
      OC_RETRY  = 2'd3
   } outcome_type;

   // Sequencer state carried between requests.
   typedef struct packed {
      phase_type        phase;
      logic [ByteW-1:0] attempt_count;
      logic [ByteW-1:0] register_latch;
   } seq_state_type;

   // One request as held in the input register.
   typedef struct packed {
      kind_type         kind;
      logic [ByteW-1:0] reg_addr;
      logic [ByteW-1:0] status;
      logic [ByteW-1:0] rx_byte;
   } req_type;

   // One response.
   typedef struct packed {
      action_type       action;
      logic [ByteW-1:0] tx_byte;
      logic             done_res;
      outcome_type      outcome;
      logic [ByteW-1:0] read_data;
   } rsp_type;

endpackage

/* rtl/i2cm_step.sv */
// Transition logic: next sequencer state and response for one request.
module i2cm_step (
   input  i2cm_pkg::req_type       req,
   input  i2cm_pkg::seq_state_type state,
   input  logic [7:0]              slave_address,
   input  logic [7:0]              max_attempts,
   output i2cm_pkg::seq_state_type state_next,
   output i2cm_pkg::rsp_type       rsp
);

   logic [7:0] st;
   logic [7:0] sla;

   assign st  = {req.status[7:3], 3'b000};
   assign sla = {slave_address[7:1], 1'b0};

   always_comb begin
      state_next = state;
      rsp        = '0;
      rsp.action = i2cm_pkg::ACT_NONE;
      rsp.outcome = i2cm_pkg::OC_BYTE;

      if (req.kind == i2cm_pkg::KIND_BEGIN) begin
         // A begin is taken only while idle.
         if (state.phase == i2cm_pkg::PH_IDLE) begin
            state_next.register_latch = req.reg_addr;
            if (max_attempts == 8'd0) begin
               state_next.attempt_count = 8'd0;
               rsp.done_res = 1'b1;
               rsp.outcome  = i2cm_pkg::OC_RETRY;
            end else begin
               state_next.attempt_count = 8'd1;
               state_next.phase = i2cm_pkg::PH_START;
               rsp.action = i2cm_pkg::ACT_START;
            end
         end
      end else begin
         // Bus status event advances the sequence.
         unique case (state.phase)
            i2cm_pkg::PH_START: begin
               if (st == i2cm_pkg::ST_START || st == i2cm_pkg::ST_RSTART) begin
                  state_next.phase = i2cm_pkg::PH_SLAW;
                  rsp.action  = i2cm_pkg::ACT_SEND;
                  rsp.tx_byte = sla;
               end else if (st == i2cm_pkg::ST_ARB_LOST) begin
                  state_next.phase = i2cm_pkg::PH_START;
                  rsp.action = i2cm_pkg::ACT_START;
               end else begin
                  // Failed first start ends without a stop.
                  state_next.phase = i2cm_pkg::PH_IDLE;
                  rsp.done_res = 1'b1;
                  rsp.outcome  = i2cm_pkg::OC_ERROR;
               end
            end
            i2cm_pkg::PH_SLAW: begin
               if (st == i2cm_pkg::ST_SLAW_ACK) begin
                  state_next.phase = i2cm_pkg::PH_REG;
                  rsp.action  = i2cm_pkg::ACT_SEND;
                  rsp.tx_byte = state.register_latch;
               end else if (st == i2cm_pkg::ST_SLAW_NACK) begin
                  if (state.attempt_count >= max_attempts) begin
                     state_next.phase = i2cm_pkg::PH_IDLE;
                     rsp.done_res = 1'b1;
                     rsp.outcome  = i2cm_pkg::OC_RETRY;
                  end else begin
                     state_next.attempt_count = state.attempt_count + 8'd1;
                     state_next.phase = i2cm_pkg::PH_START;
                     rsp.action = i2cm_pkg::ACT_START;
                  end
               end else if (st == i2cm_pkg::ST_ARB_LOST) begin
                  state_next.phase = i2cm_pkg::PH_START;
                  rsp.action = i2cm_pkg::ACT_START;
               end else begin
                  state_next.phase = i2cm_pkg::PH_IDLE;
                  rsp.action   = i2cm_pkg::ACT_STOP;
                  rsp.done_res = 1'b1;
                  rsp.outcome  = i2cm_pkg::OC_ERROR;
               end
            end
            i2cm_pkg::PH_REG: begin
               if (st == i2cm_pkg::ST_TXD_ACK) begin
                  state_next.phase = i2cm_pkg::PH_RSTART;
                  rsp.action = i2cm_pkg::ACT_START;
               end else if (st == i2cm_pkg::ST_TXD_NACK) begin
                  state_next.phase = i2cm_pkg::PH_IDLE;
                  rsp.action   = i2cm_pkg::ACT_STOP;
                  rsp.done_res = 1'b1;
                  rsp.outcome  = i2cm_pkg::OC_NODATA;
               end else if (st == i2cm_pkg::ST_ARB_LOST) begin
                  state_next.phase = i2cm_pkg::PH_START;
                  rsp.action = i2cm_pkg::ACT_START;
               end else begin
                  state_next.phase = i2cm_pkg::PH_IDLE;
                  rsp.action   = i2cm_pkg::ACT_STOP;
                  rsp.done_res = 1'b1;
                  rsp.outcome  = i2cm_pkg::OC_ERROR;
               end
            end
            i2cm_pkg::PH_RSTART: begin
               if (st == i2cm_pkg::ST_START || st == i2cm_pkg::ST_RSTART) begin
                  state_next.phase = i2cm_pkg::PH_SLAR;
                  rsp.action  = i2cm_pkg::ACT_SEND;
                  rsp.tx_byte = {sla[7:1], 1'b1};
               end else if (st == i2cm_pkg::ST_ARB_LOST) begin
                  state_next.phase = i2cm_pkg::PH_START;
                  rsp.action = i2cm_pkg::ACT_START;
               end else begin
                  state_next.phase = i2cm_pkg::PH_IDLE;
                  rsp.action   = i2cm_pkg::ACT_STOP;
                  rsp.done_res = 1'b1;
                  rsp.outcome  = i2cm_pkg::OC_ERROR;
               end
            end
            i2cm_pkg::PH_SLAR: begin
               if (st == i2cm_pkg::ST_SLAR_ACK) begin
                  state_next.phase = i2cm_pkg::PH_DATA;
                  rsp.action = i2cm_pkg::ACT_RECV;
               end else if (st == i2cm_pkg::ST_SLAR_NACK) begin
                  state_next.phase = i2cm_pkg::PH_IDLE;
                  rsp.action   = i2cm_pkg::ACT_STOP;
                  rsp.done_res = 1'b1;
                  rsp.outcome  = i2cm_pkg::OC_NODATA;
               end else if (st == i2cm_pkg::ST_ARB_LOST) begin
                  state_next.phase = i2cm_pkg::PH_START;
                  rsp.action = i2cm_pkg::ACT_START;
               end else begin
                  state_next.phase = i2cm_pkg::PH_IDLE;
                  rsp.action   = i2cm_pkg::ACT_STOP;
                  rsp.done_res = 1'b1;
                  rsp.outcome  = i2cm_pkg::OC_ERROR;
               end
            end
            i2cm_pkg::PH_DATA: begin
               // Any status other than data received with NACK is an error.
               state_next.phase = i2cm_pkg::PH_IDLE;
               rsp.action   = i2cm_pkg::ACT_STOP;
               rsp.done_res = 1'b1;
               if (st == i2cm_pkg::ST_RXD_NACK) begin
                  rsp.outcome   = i2cm_pkg::OC_BYTE;
                  rsp.read_data = req.rx_byte;
               end else begin
                  rsp.outcome = i2cm_pkg::OC_ERROR;
               end
            end
            default: begin
               // Status while idle is ignored.
               state_next.phase = i2cm_pkg::PH_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/i2c_master_register_read_fsm.sv */
// Top level of the two-wire master register read sequencer.
//
// Usage: the request channel carries either a begin (tuser low, register
// address in tdata) or a bus status event (tuser high, status and received
// byte in tdata). Every request yields exactly one response that tells the
// bus controller the next action: none, start, send tx_byte, receive with
// NACK, or stop. rsp_tlast marks the response that ends a transaction;
// the outcome and the byte read are valid with it.
// From request acceptance to rsp_tvalid a request passes the input register,
// then the transition logic into the response register. Throughput is one
// request per cycle while rsp_tready stays high; the input register and the
// response register form a two-stage pipeline, so a new request is taken
// while a finished response still waits. When the receiver stalls, the
// response register holds and the input register fills, after which
// req_tready drops. A synchronous reset empties both stages, returns the
// sequencer to idle and restores the configuration registers to their
// reset values. Configuration writes are registered; the user must make
// them only while no request is in flight, which the block does not enforce.
module i2c_master_register_read_fsm (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [i2cm_pkg::ReqDataW-1:0]      req_tdata,  // reg_addr, status, rx_byte
   input  logic                               req_tuser,  // kind
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [i2cm_pkg::RspDataW-1:0]      rsp_tdata,  // action, tx_byte, outcome,
                                                          // read_data, zero pad
   output logic                               rsp_tlast,  // done_res
   // Configuration port.
   input  logic                               csr_we,
   input  logic [i2cm_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [i2cm_pkg::CsrDataW-1:0]      csr_wdata
);

   logic                     in_valid_ff;
   i2cm_pkg::req_type        in_req_ff;
   logic                     out_valid_ff;
   i2cm_pkg::rsp_type        out_rsp_ff;
   i2cm_pkg::seq_state_type  state_ff;
   i2cm_pkg::seq_state_type  state_in;
   i2cm_pkg::rsp_type        rsp_in;
   logic [7:0]               slave_address_ff;
   logic [7:0]               max_attempts_ff;
   logic                     advance;
   logic                     req_fire;

   // Pipeline flow control.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Transition logic.
   i2cm_step u_step (
      .req           (in_req_ff),
      .state         (state_ff),
      .slave_address (slave_address_ff),
      .max_attempts  (max_attempts_ff),
      .state_next    (state_in),
      .rsp           (rsp_in)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_fire) begin
         in_req_ff.kind     <= i2cm_pkg::kind_type'(req_tuser);
         in_req_ff.reg_addr <= req_tdata[7:0];
         in_req_ff.status   <= req_tdata[15:8];
         in_req_ff.rx_byte  <= req_tdata[23:16];
      end
   end

   // Sequencer state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_rsp_ff <= rsp_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd0;
         max_attempts_ff  <= i2cm_pkg::MAX_ATTEMPTS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            i2cm_pkg::CSR_SLAVE_ADDRESS: slave_address_ff <= csr_wdata;
            i2cm_pkg::CSR_MAX_ATTEMPTS:  max_attempts_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Response packing.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_rsp_ff.done_res;
   assign rsp_tdata  = {3'b000, out_rsp_ff.read_data, out_rsp_ff.outcome,
                        out_rsp_ff.tx_byte, out_rsp_ff.action};

endmodule

/* rtl/i2cm_checker.sv */
// Port-level checks on the register read sequencer and their binding.
module i2cm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [i2cm_pkg::RspDataW-1:0] rsp_tdata,
   input logic                          rsp_tlast
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // A finishing response commands only none or stop.
   a_done_action: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tdata[2:0] == i2cm_pkg::ACT_NONE || rsp_tdata[2:0] == i2cm_pkg::ACT_STOP))
      else $error("finishing response with a bus action other than stop");

   // Outcome and read data stay clear until the transaction ends.
   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[20:11] == 10'd0)
      else $error("outcome or data reported before the end");

   // A transmit byte is shown only with a send action.
   a_tx_only_send: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != i2cm_pkg::ACT_SEND |-> rsp_tdata[10:3] == 8'd0)
      else $error("transmit byte without a send action");

   // The response channel is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind i2c_master_register_read_fsm i2cm_checker u_i2cm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* sim/tb_i2c_master_register_read_fsm.sv */
// Self-checking testbench for the two-wire register read sequencer, directed and random traffic.
`timescale 1ns / 100ps

module tb_i2c_master_register_read_fsm;

   // Clock, reset and block ports.
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [i2cm_pkg::ReqDataW-1:0]  req_tdata = '0;   // reg_addr, status, rx_byte
   logic                           req_tuser = 1'b0; // kind
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [i2cm_pkg::RspDataW-1:0]  rsp_tdata;        // action, tx_byte, outcome, read_data, pad
   logic                           rsp_tlast;        // done_res
   logic                           csr_we = 1'b0;
   logic [i2cm_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [i2cm_pkg::CsrDataW-1:0]  csr_wdata = '0;

   // Predicted sequencer state and configuration.
   i2cm_pkg::phase_type            seq_phase = i2cm_pkg::PH_IDLE;
   logic [i2cm_pkg::ByteW-1:0]     attempts = '0;
   logic [i2cm_pkg::ByteW-1:0]     latched_reg = '0;
   logic [i2cm_pkg::ByteW-1:0]     slave_addr_q = '0;
   logic [i2cm_pkg::ByteW-1:0]     attempt_limit = i2cm_pkg::MAX_ATTEMPTS_RESET;

   // Responses still owed by the block, oldest first.
   i2cm_pkg::rsp_type              owed_rsp_q[$];
   int                             error_count = 0;

   // Sender burst bookkeeping.
   bit                             req_active = 1'b0;
   int                             burst_left = 0;

   i2c_master_register_read_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Ends a transaction: back to idle with the given action and outcome.
   function automatic i2cm_pkg::rsp_type end_transfer(input i2cm_pkg::action_type act,
                                                      input i2cm_pkg::outcome_type oc,
                                                      input logic [i2cm_pkg::ByteW-1:0] data);
      i2cm_pkg::rsp_type o;
      o = '0;
      seq_phase = i2cm_pkg::PH_IDLE;
      o.action = act;
      o.done_res = 1'b1;
      o.outcome = oc;
      o.read_data = data;
      return o;
   endfunction

   // Commands a fresh start and waits for the first start status again.
   function automatic i2cm_pkg::rsp_type start_again();
      i2cm_pkg::rsp_type o;
      o = '0;
      seq_phase = i2cm_pkg::PH_START;
      o.action = i2cm_pkg::ACT_START;
      return o;
   endfunction

   // Predicts the response to one request and advances the predicted state.
   function automatic i2cm_pkg::rsp_type predict_read_step(input i2cm_pkg::req_type r);
      i2cm_pkg::rsp_type          o;
      logic [i2cm_pkg::ByteW-1:0] st;
      logic [i2cm_pkg::ByteW-1:0] sla;
      o = '0;
      st = r.status & 8'hF8;
      sla = slave_addr_q & 8'hFE;
      if (r.kind == i2cm_pkg::KIND_BEGIN) begin
         // A begin while a transaction runs is ignored.
         if (seq_phase != i2cm_pkg::PH_IDLE) return o;
         latched_reg = r.reg_addr;
         if (attempt_limit == 0) begin
            attempts = '0;
            return end_transfer(i2cm_pkg::ACT_NONE, i2cm_pkg::OC_RETRY, 8'h00);
         end
         attempts = 8'd1;
         return start_again();
      end
      case (seq_phase)
         i2cm_pkg::PH_START: begin
            if (st == i2cm_pkg::ST_START || st == i2cm_pkg::ST_RSTART) begin
               seq_phase = i2cm_pkg::PH_SLAW;
               o.action = i2cm_pkg::ACT_SEND;
               o.tx_byte = sla;
            end else if (st == i2cm_pkg::ST_ARB_LOST) begin
               o = start_again();
            end else begin
               o = end_transfer(i2cm_pkg::ACT_NONE, i2cm_pkg::OC_ERROR, 8'h00);
            end
         end
         i2cm_pkg::PH_SLAW: begin
            if (st == i2cm_pkg::ST_SLAW_ACK) begin
               seq_phase = i2cm_pkg::PH_REG;
               o.action = i2cm_pkg::ACT_SEND;
               o.tx_byte = latched_reg;
            end else if (st == i2cm_pkg::ST_SLAW_NACK) begin
               // Retry the address until the attempt limit is reached.
               if (attempts >= attempt_limit) begin
                  o = end_transfer(i2cm_pkg::ACT_NONE, i2cm_pkg::OC_RETRY, 8'h00);
               end else begin
                  attempts = attempts + 8'd1;
                  o = start_again();
               end
            end else if (st == i2cm_pkg::ST_ARB_LOST) begin
               o = start_again();
            end else begin
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_ERROR, 8'h00);
            end
         end
         i2cm_pkg::PH_REG: begin
            if (st == i2cm_pkg::ST_TXD_ACK) begin
               seq_phase = i2cm_pkg::PH_RSTART;
               o.action = i2cm_pkg::ACT_START;
            end else if (st == i2cm_pkg::ST_TXD_NACK) begin
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_NODATA, 8'h00);
            end else if (st == i2cm_pkg::ST_ARB_LOST) begin
               o = start_again();
            end else begin
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_ERROR, 8'h00);
            end
         end
         i2cm_pkg::PH_RSTART: begin
            if (st == i2cm_pkg::ST_START || st == i2cm_pkg::ST_RSTART) begin
               seq_phase = i2cm_pkg::PH_SLAR;
               o.action = i2cm_pkg::ACT_SEND;
               o.tx_byte = sla | 8'h01;
            end else if (st == i2cm_pkg::ST_ARB_LOST) begin
               o = start_again();
            end else begin
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_ERROR, 8'h00);
            end
         end
         i2cm_pkg::PH_SLAR: begin
            if (st == i2cm_pkg::ST_SLAR_ACK) begin
               seq_phase = i2cm_pkg::PH_DATA;
               o.action = i2cm_pkg::ACT_RECV;
            end else if (st == i2cm_pkg::ST_SLAR_NACK) begin
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_NODATA, 8'h00);
            end else if (st == i2cm_pkg::ST_ARB_LOST) begin
               o = start_again();
            end else begin
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_ERROR, 8'h00);
            end
         end
         i2cm_pkg::PH_DATA: begin
            // Arbitration lost here counts as a bus error.
            if (st == i2cm_pkg::ST_RXD_NACK)
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_BYTE, r.rx_byte);
            else
               o = end_transfer(i2cm_pkg::ACT_STOP, i2cm_pkg::OC_ERROR, 8'h00);
         end
         i2cm_pkg::PH_IDLE: begin
            // A status event while idle is ignored.
         end
         default: seq_phase = i2cm_pkg::PH_IDLE;
      endcase
      return o;
   endfunction

   // Builds one request.
   function automatic i2cm_pkg::req_type make_req(input i2cm_pkg::kind_type kind,
                                                  input logic [i2cm_pkg::ByteW-1:0] reg_addr,
                                                  input logic [i2cm_pkg::ByteW-1:0] status,
                                                  input logic [i2cm_pkg::ByteW-1:0] rx_byte);
      i2cm_pkg::req_type r;
      r.kind = kind;
      r.reg_addr = reg_addr;
      r.status = status;
      r.rx_byte = rx_byte;
      return r;
   endfunction

   // Picks a request that mostly follows the expected bus sequence.
   function automatic i2cm_pkg::req_type pick_bus_request();
      i2cm_pkg::req_type          r;
      logic [i2cm_pkg::ByteW-1:0] good;
      logic [i2cm_pkg::ByteW-1:0] alt;
      int                         pick;
      r = make_req(i2cm_pkg::KIND_STATUS, 8'($urandom), 8'h00, 8'($urandom));
      pick = $urandom_range(0, 99);
      case (seq_phase)
         i2cm_pkg::PH_START: begin
            good = pick[0] ? i2cm_pkg::ST_START : i2cm_pkg::ST_RSTART;
            alt = i2cm_pkg::ST_START;
         end
         i2cm_pkg::PH_SLAW: begin
            good = i2cm_pkg::ST_SLAW_ACK;
            alt = i2cm_pkg::ST_SLAW_NACK;
         end
         i2cm_pkg::PH_REG: begin
            good = i2cm_pkg::ST_TXD_ACK;
            alt = i2cm_pkg::ST_TXD_NACK;
         end
         i2cm_pkg::PH_RSTART: begin
            good = pick[0] ? i2cm_pkg::ST_RSTART : i2cm_pkg::ST_START;
            alt = i2cm_pkg::ST_RSTART;
         end
         i2cm_pkg::PH_SLAR: begin
            good = i2cm_pkg::ST_SLAR_ACK;
            alt = i2cm_pkg::ST_SLAR_NACK;
         end
         default: begin
            good = i2cm_pkg::ST_RXD_NACK;
            alt = i2cm_pkg::ST_RXD_NACK;
         end
      endcase
      if (seq_phase == i2cm_pkg::PH_IDLE) begin
         // Mostly begins; a few stray status events.
         if (pick < 92) r.kind = i2cm_pkg::KIND_BEGIN;
         r.status = 8'($urandom);
      end else if (pick < 75) begin
         r.status = good | 8'($urandom_range(0, 7));
      end else if (pick < 86) begin
         r.status = alt | 8'($urandom_range(0, 7));
      end else if (pick < 92) begin
         r.status = i2cm_pkg::ST_ARB_LOST | 8'($urandom_range(0, 7));
      end else if (pick < 97) begin
         r.status = 8'($urandom);
      end else begin
         // A begin out of turn.
         r.kind = i2cm_pkg::KIND_BEGIN;
         r.status = 8'($urandom);
      end
      return r;
   endfunction

   // Lowers the request valid if it is up.
   task automatic hold_requests();
      if (req_active) begin
         req_tvalid <= 1'b0;
         req_active = 1'b0;
      end
   endtask

   // Sends one request, records its prediction and idles between bursts.
   task automatic send_request(input i2cm_pkg::req_type r);
      int gap;
      if (!req_active) begin
         req_tvalid <= 1'b1;
         req_active = 1'b1;
      end
      req_tdata <= {r.rx_byte, r.status, r.reg_addr};
      req_tuser <= r.kind;
      do @(posedge clock); while (!req_tready);
      owed_rsp_q.push_back(predict_read_step(r));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // Now and then a long stretch with no idling at all.
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            hold_requests();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Waits until every owed response has come back and the block is quiet.
   task automatic wait_idle();
      hold_requests();
      while (owed_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both configuration registers; only called while the block is idle.
   task automatic set_config(input logic [i2cm_pkg::ByteW-1:0] slave,
                             input logic [i2cm_pkg::ByteW-1:0] limit);
      csr_we <= 1'b1;
      csr_index <= i2cm_pkg::CSR_SLAVE_ADDRESS;
      csr_wdata <= slave;
      @(posedge clock);
      slave_addr_q = slave;
      csr_index <= i2cm_pkg::CSR_MAX_ATTEMPTS;
      csr_wdata <= limit;
      @(posedge clock);
      attempt_limit = limit;
      csr_we <= 1'b0;
   endtask

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Receiver stall pattern, in one of four modes drawn at random.
   int ready_mode = 0;
   int ready_cycle = 0;
   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle % 50 == 49) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (ready_cycle % 4 == 0);
         default: rsp_tready <= (ready_cycle % 8 == 7);
      endcase
   end

   // Response checker: each response against the oldest owed one.
   always @(posedge clock) begin
      i2cm_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_rsp_q.size() == 0) begin
            report_mismatch("response with none owed", int'(rsp_tdata), 0);
         end else begin
            want = owed_rsp_q.pop_front();
            if (rsp_tdata[2:0] != want.action)
               report_mismatch("action", int'(rsp_tdata[2:0]), int'(want.action));
            if (rsp_tdata[10:3] != want.tx_byte)
               report_mismatch("tx_byte", int'(rsp_tdata[10:3]), int'(want.tx_byte));
            if (rsp_tlast != want.done_res)
               report_mismatch("done_res", int'(rsp_tlast), int'(want.done_res));
            if (rsp_tdata[12:11] != want.outcome)
               report_mismatch("outcome", int'(rsp_tdata[12:11]), int'(want.outcome));
            if (rsp_tdata[20:13] != want.read_data)
               report_mismatch("read_data", int'(rsp_tdata[20:13]), int'(want.read_data));
            if (rsp_tdata[23:21] != 3'b000)
               report_mismatch("pad bits", int'(rsp_tdata[23:21]), 0);
         end
      end
   end

   // A complete read with the reset configuration, low status bits set on one event.
   task automatic test_reset_read();
      send_request(make_req(i2cm_pkg::KIND_BEGIN, 8'hFF, 8'h00, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, 8'h0F, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_SLAW_ACK, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_TXD_ACK, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_RSTART, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_SLAR_ACK, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'hFF, i2cm_pkg::ST_RXD_NACK, 8'hFF));
   endtask

   // Status while idle and a begin while busy are both ignored.
   task automatic test_out_of_turn();
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'hFF, i2cm_pkg::ST_START, 8'hFF));
      send_request(make_req(i2cm_pkg::KIND_BEGIN, 8'h5A, 8'hFF, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_BEGIN, 8'hA5, 8'h00, 8'h00));
      // A bad first start status ends with a bus error and no stop.
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_RXD_NACK, 8'h00));
   endtask

   // Arbitration lost, retries exhausted, not-acknowledged register byte.
   task automatic test_bus_faults();
      wait_idle();
      set_config(8'hFE, 8'd1);
      send_request(make_req(i2cm_pkg::KIND_BEGIN, 8'h00, 8'h00, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_ARB_LOST, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_START, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_SLAW_NACK, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_BEGIN, 8'hA5, 8'h00, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_RSTART, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_SLAW_ACK, 8'h00));
      send_request(make_req(i2cm_pkg::KIND_STATUS, 8'h00, i2cm_pkg::ST_TXD_NACK, 8'h00));
   endtask

   // A zero attempt limit ends every begin at once.
   task automatic test_zero_attempts();
      wait_idle();
      set_config(8'h01, 8'd0);
      send_request(make_req(i2cm_pkg::KIND_BEGIN, 8'h3C, 8'h00, 8'h00));
   endtask

   // Random transactions over several configurations, extremes among them.
   task automatic test_random_reads();
      int                counted;
      int                phase_items;
      int                quota;
      int                setting;
      i2cm_pkg::req_type r;
      bit                ignored;
      counted = 0;
      setting = 0;
      while (counted < 400) begin
         wait_idle();
         case (setting % 6)
            0:       set_config(8'hFE, 8'd255);
            1:       set_config(8'h00, 8'd1);
            2:       set_config(8'h01, 8'd2);
            3:       set_config(8'($urandom_range(0, 254)), 8'($urandom_range(1, 4)));
            4:       set_config(8'($urandom_range(0, 254)), 8'd0);
            default: set_config(8'($urandom_range(0, 254)), 8'd3);
         endcase
         quota = (attempt_limit == 0) ? 10 : 70;
         phase_items = 0;
         while (phase_items < quota) begin
            r = pick_bus_request();
            ignored = (r.kind == i2cm_pkg::KIND_BEGIN) ? (seq_phase != i2cm_pkg::PH_IDLE)
                                                       : (seq_phase == i2cm_pkg::PH_IDLE);
            send_request(r);
            if (!ignored) phase_items++;
         end
         counted += phase_items;
         setting++;
      end
   endtask

   // Test sequence.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_read();
      test_out_of_turn();
      test_bus_faults();
      test_zero_attempts();
      test_random_reads();
      hold_requests();
      for (int i = 0; i < 2000 && owed_rsp_q.size() != 0; i++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (owed_rsp_q.size() != 0) report_mismatch("responses never returned", owed_rsp_q.size(), 0);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
